### rtl/dtcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtcd_pkg;

    localparam int DAY_COUNT_W = 16;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 12;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DAY_W - MONTH_W - YEAR_W;

    localparam logic [15:0] CYCLE_DAYS    = 16'd1461;
    localparam logic [31:0] CYCLE_RECIP   = 32'd45934;   // ceil(2^26 / 1461)
    localparam int          RECIP_SHIFT   = 26;
    localparam logic [11:0] BASE_YEAR     = 12'd2000;
    localparam logic [10:0] YEAR1_START   = 11'd366;
    localparam logic [10:0] YEAR2_START   = 11'd731;
    localparam logic [10:0] YEAR3_START   = 11'd1096;
    localparam logic [8:0]  LEAP_DAY_IDX  = 9'd59;
    localparam logic [4:0]  FEB_LEAP_DAY  = 5'd29;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [4:0]  DAY_FIRST     = 5'd1;
    localparam logic [4:0]  DAY_LAST      = 5'd31;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_number;
        logic [MONTH_W-1:0] month_number;
        logic [DAY_W-1:0]   day_of_month;
    } dtcd_date_t;

    // first zero-based day of year of each month, common year
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] val;
        case (idx)
            4'd0:    val = 9'd0;
            4'd1:    val = 9'd31;
            4'd2:    val = 9'd59;
            4'd3:    val = 9'd90;
            4'd4:    val = 9'd120;
            4'd5:    val = 9'd151;
            4'd6:    val = 9'd181;
            4'd7:    val = 9'd212;
            4'd8:    val = 9'd243;
            4'd9:    val = 9'd273;
            4'd10:   val = 9'd304;
            4'd11:   val = 9'd334;
            4'd12:   val = 9'd365;
            default: val = 9'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### rtl/dtcd_convert.sv
`timescale 1ns / 1ps
`default_nettype none

module dtcd_convert
    import dtcd_pkg::*;
(
    input  wire logic [DAY_COUNT_W-1:0] day_count,
    output dtcd_date_t                  date
);

    logic [31:0] recip_prod;
    logic [5:0]  cycle_idx;
    logic [15:0] cycle_base;
    logic [10:0] cycle_rem;
    logic [1:0]  year_in_cycle;
    logic [8:0]  year_day;
    logic        leap;
    logic        leap_feb29;
    logic [8:0]  adj_day;
    logic [3:0]  month_idx;
    logic [8:0]  month_base;
    logic [8:0]  day_in_month;

    always_comb
    begin
        recip_prod = 32'(day_count) * CYCLE_RECIP;
        cycle_idx  = recip_prod[RECIP_SHIFT +: 6];
        cycle_base = 16'({10'd0, cycle_idx} * CYCLE_DAYS);
        cycle_rem  = 11'(day_count - cycle_base);

        if (cycle_rem < YEAR1_START)
        begin
            year_in_cycle = 2'd0;
            year_day      = 9'(cycle_rem);
        end
        else if (cycle_rem < YEAR2_START)
        begin
            year_in_cycle = 2'd1;
            year_day      = 9'(cycle_rem - YEAR1_START);
        end
        else if (cycle_rem < YEAR3_START)
        begin
            year_in_cycle = 2'd2;
            year_day      = 9'(cycle_rem - YEAR2_START);
        end
        else
        begin
            year_in_cycle = 2'd3;
            year_day      = 9'(cycle_rem - YEAR3_START);
        end

        leap       = (year_in_cycle == 2'd0);
        leap_feb29 = leap && (year_day == LEAP_DAY_IDX);
        adj_day    = (leap && (year_day > LEAP_DAY_IDX)) ? year_day - 9'd1 : year_day;

        month_idx = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (adj_day >= month_start(4'(k)))
            begin
                month_idx = month_idx + 4'd1;
            end
        end
        month_base   = month_start(month_idx);
        day_in_month = adj_day - month_base + 9'd1;

        date.year_number = BASE_YEAR + {4'd0, cycle_idx, 2'b00} + {10'd0, year_in_cycle};
        if (leap_feb29)
        begin
            date.month_number = MONTH_FEB;
            date.day_of_month = FEB_LEAP_DAY;
        end
        else
        begin
            date.month_number = month_idx + 4'd1;
            date.day_of_month = day_in_month[DAY_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/days_to_calendar_date_core.sv
// channel  dir  width  contents
// s        in   16     tdata: day_count[15:0]
// m        out  24     tdata: day_of_month[4:0], month_number[8:5], year_number[20:9], zero
//
// One item per cycle sustained while m does not stall; m_tvalid rises when the result
// register loads. The conversion sits between the input register and the result register.
// rst_n clears both valid flags; data registers are not reset.
// A stall on m holds the result register; s keeps accepting while the input
// register is empty or can move into the result register in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module days_to_calendar_date_core
    import dtcd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // day_count[15:0]
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata    // day_of_month, month_number, year_number, pad
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [DAY_COUNT_W-1:0] in_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    dtcd_date_t             out_data_reg;
    dtcd_date_t             conv_date;
    logic                   out_free;
    logic                   advance;
    logic                   load;

    dtcd_convert u_convert (
        .day_count (in_data_reg),
        .date      (conv_date)
    );

    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        advance  = in_valid_reg && out_free;
        s_tready = !in_valid_reg || out_free;
        load     = s_tvalid && s_tready;

        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_data_reg <= s_tdata[DAY_COUNT_W-1:0];
        end
        if (advance)
        begin
            out_data_reg <= conv_date;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_data_reg.year_number,
                       out_data_reg.month_number, out_data_reg.day_of_month};

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg.month_number >= MONTH_JAN &&
                      out_data_reg.month_number <= MONTH_DEC))
        else $error("month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg.day_of_month >= DAY_FIRST &&
                      out_data_reg.day_of_month <= DAY_LAST))
        else $error("day out of range");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("accept while pipeline full");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=>
            (in_valid_reg && $stable(in_data_reg)))
        else $error("input register lost during stall");

endmodule

`default_nettype wire
